FILE: hw/rtl/rwnh_pkg.sv
package rwnh_pkg;

   // Action codes carried by the req_action field.
   localparam logic [1:0] ACT_NODE_WR = 2'd0;
   localparam logic [1:0] ACT_LINK_WR = 2'd1;
   localparam logic [1:0] ACT_STEP    = 2'd2;
   localparam logic [1:0] ACT_DRAW    = 2'd3;

   // Generator constants.
   localparam int unsigned TW_N         = 624;
   localparam logic [9:0]  TW_LAST      = 10'd623;
   localparam logic [9:0]  TW_M         = 10'd397;
   localparam logic [9:0]  TW_WRAP      = 10'd227;
   localparam logic [31:0] TW_SEED      = 32'd20260912;
   localparam logic [31:0] TW_MULT      = 32'd1812433253;
   localparam logic [31:0] TW_MAGIC     = 32'h9908b0df;
   localparam logic [31:0] TW_TEMPER_B  = 32'h9d2c5680;
   localparam logic [31:0] TW_TEMPER_C  = 32'hefc60000;

   typedef enum logic [1:0] {
      KIND_NODE_WR,
      KIND_LINK_WR,
      KIND_STEP,
      KIND_DRAW
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] index;
      logic [11:0] first;
      logic [7:0]  links;
      logic [15:0] target;
      logic [15:0] node;
      logic [15:0] from;
   } cmd_type;

endpackage

FILE: hw/rtl/rwnh_front.sv
module rwnh_front
   import rwnh_pkg::*;
#(
   parameter int NODE_DEPTH = 1024,
   parameter int LINK_DEPTH = 4096
) (
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_entry_index,
   input  logic [11:0] req_first_link,
   input  logic [7:0]  req_link_count,
   input  logic [15:0] req_link_target,
   input  logic [15:0] req_current_node,
   input  logic [15:0] req_came_from,
   output logic        push,
   output cmd_type     cmd
);

   logic        accept;
   logic [16:0] entry_wide;
   logic        keep;

   assign accept     = start && !busy;
   assign entry_wide = {5'b0, req_entry_index};

   // Writes that fall outside their store are dropped here and never queued.
   always_comb begin
      cmd.index  = req_entry_index;
      cmd.first  = req_first_link;
      cmd.links  = req_link_count;
      cmd.target = req_link_target;
      cmd.node   = req_current_node;
      cmd.from   = req_came_from;
      keep       = 1'b1;
      case (req_action)
         ACT_NODE_WR: begin
            cmd.kind = KIND_NODE_WR;
            keep     = entry_wide < 17'(NODE_DEPTH);
         end
         ACT_LINK_WR: begin
            cmd.kind = KIND_LINK_WR;
            keep     = entry_wide < 17'(LINK_DEPTH);
         end
         ACT_STEP: cmd.kind = KIND_STEP;
         default:  cmd.kind = KIND_DRAW;
      endcase
   end

   assign push = accept && keep;

endmodule

FILE: hw/rtl/rwnh_queue.sv
module rwnh_queue
   import rwnh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hw/rtl/rwnh_back.sv
module rwnh_back
   import rwnh_pkg::*;
#(
   parameter int NODE_DEPTH = 1024,
   parameter int LINK_DEPTH = 4096,
   parameter int MAX_PICKS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   input  logic [10:0] node_count,
   output logic        cmd_pop,
   output logic        init_busy,
   output logic        rsp_valid,
   output logic [31:0] rsp_value
);

   localparam int NA  = $clog2(NODE_DEPTH);
   localparam int LA  = $clog2(LINK_DEPTH);
   localparam int HW  = $clog2(MAX_PICKS + 1);
   localparam int PIW = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;

   typedef enum logic [3:0] {
      ST_SEED, ST_INIT_MUL, ST_INIT_WR, ST_IDLE, ST_NODE_RD, ST_SCAN_ADDR,
      ST_SCAN_DATA, ST_TW_RD1, ST_TW_RD2, ST_TW_CALC, ST_MOD, ST_PICK
   } state_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TW_TEMPER_B);
      y = y ^ ((y << 15) & TW_TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   state_type     state_ff;
   logic [19:0]   node_mem [NODE_DEPTH];
   logic [15:0]   link_mem [LINK_DEPTH];
   logic [31:0]   tw_mem   [TW_N];
   logic [19:0]   node_rd_ff;
   logic [15:0]   link_rd_ff;
   logic [31:0]   tw_rda_ff;
   logic [31:0]   tw_rdb_ff;

   cmd_type       cur_ff;
   logic [11:0]   first_ff;
   logic [7:0]    links_ff;
   logic [7:0]    i_ff;
   logic [HW-1:0] held_ff;
   logic [15:0]   picks_ff [MAX_PICKS];
   logic          raw_ff;
   logic [9:0]    pos_ff;
   logic [9:0]    k_ff;
   logic [31:0]   prev_ff;
   logic [31:0]   prod_ff;
   logic [31:0]   y_ff;
   logic [31:0]   word_ff;
   logic [HW-1:0] rem_ff;
   logic [4:0]    bit_ff;

   logic [16:0]   limit;
   logic [16:0]   li;
   logic [9:0]    pos_next;
   logic [9:0]    pos_far;
   logic [9:0]    tw_ra;
   logic [9:0]    tw_rb;
   logic          tw_we;
   logic [9:0]    tw_wa;
   logic [31:0]   tw_wd;
   logic [31:0]   twisted;
   logic [31:0]   init_val;
   logic [HW:0]   rem_sh;
   logic [HW-1:0] rem_in;
   logic          node_we;
   logic          link_we;

   assign limit    = ({6'b0, node_count} < 17'(NODE_DEPTH)) ? {6'b0, node_count}
                                                            : 17'(NODE_DEPTH);
   assign li       = {5'b0, first_ff} + {9'b0, i_ff};
   assign pos_next = (pos_ff == TW_LAST) ? 10'd0 : pos_ff + 10'd1;
   assign pos_far  = (pos_ff < TW_WRAP) ? pos_ff + TW_M : pos_ff - TW_WRAP;
   assign twisted  = tw_rdb_ff ^ (y_ff >> 1) ^ (y_ff[0] ? TW_MAGIC : 32'd0);
   assign init_val = prod_ff + {22'b0, k_ff};
   assign rem_sh   = {rem_ff, word_ff[31]};
   assign rem_in   = (rem_sh >= {1'b0, held_ff}) ? HW'(rem_sh - {1'b0, held_ff})
                                                 : HW'(rem_sh);

   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign init_busy = (state_ff == ST_SEED) || (state_ff == ST_INIT_MUL) ||
                      (state_ff == ST_INIT_WR);
   assign node_we   = cmd_pop && (cmd.kind == KIND_NODE_WR);
   assign link_we   = cmd_pop && (cmd.kind == KIND_LINK_WR);

   always_comb begin
      tw_ra = pos_ff;
      tw_rb = (state_ff == ST_TW_RD2) ? pos_far : pos_next;
      tw_we = 1'b0;
      tw_wa = pos_ff;
      tw_wd = twisted;
      case (state_ff)
         ST_SEED: begin
            tw_we = 1'b1;
            tw_wa = 10'd0;
            tw_wd = TW_SEED;
         end
         ST_INIT_WR: begin
            tw_we = 1'b1;
            tw_wa = k_ff;
            tw_wd = init_val;
         end
         ST_TW_CALC: tw_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[NA'({5'b0, cmd.index})] <= {cmd.first, cmd.links};
      end
      node_rd_ff <= node_mem[cmd.node[NA-1:0]];
      if (link_we) begin
         link_mem[LA'({5'b0, cmd.index})] <= cmd.target;
      end
      link_rd_ff <= link_mem[li[LA-1:0]];
      if (tw_we) begin
         tw_mem[tw_wa] <= tw_wd;
      end
      tw_rda_ff <= tw_mem[tw_ra];
      tw_rdb_ff <= tw_mem[tw_rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SEED;
         pos_ff    <= 10'd0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            ST_SEED: begin
               prev_ff  <= TW_SEED;
               k_ff     <= 10'd1;
               state_ff <= ST_INIT_MUL;
            end
            ST_INIT_MUL: begin
               prod_ff  <= TW_MULT * (prev_ff ^ (prev_ff >> 30));
               state_ff <= ST_INIT_WR;
            end
            ST_INIT_WR: begin
               prev_ff <= init_val;
               k_ff    <= k_ff + 10'd1;
               state_ff <= (k_ff == TW_LAST) ? ST_IDLE : ST_INIT_MUL;
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cur_ff <= cmd;
                  case (cmd.kind)
                     KIND_DRAW: begin
                        raw_ff   <= 1'b1;
                        state_ff <= ST_TW_RD1;
                     end
                     KIND_STEP: begin
                        raw_ff <= 1'b0;
                        if ({1'b0, cmd.node} >= limit) begin
                           rsp_valid <= 1'b1;
                           rsp_value <= {16'b0, cmd.from};
                        end else begin
                           state_ff <= ST_NODE_RD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_NODE_RD: begin
               first_ff <= node_rd_ff[19:8];
               links_ff <= node_rd_ff[7:0];
               i_ff     <= 8'd0;
               held_ff  <= '0;
               state_ff <= ST_SCAN_ADDR;
            end
            ST_SCAN_ADDR: begin
               if ((i_ff >= links_ff) || (held_ff == HW'(MAX_PICKS))) begin
                  if (held_ff == '0) begin
                     rsp_valid <= 1'b1;
                     rsp_value <= {16'b0, cur_ff.from};
                     state_ff  <= ST_IDLE;
                  end else begin
                     state_ff <= ST_TW_RD1;
                  end
               end else if (li >= 17'(LINK_DEPTH)) begin
                  i_ff <= i_ff + 8'd1;
               end else begin
                  state_ff <= ST_SCAN_DATA;
               end
            end
            ST_SCAN_DATA: begin
               if (({1'b0, link_rd_ff} < limit) && (link_rd_ff != cur_ff.from)) begin
                  picks_ff[held_ff[PIW-1:0]] <= link_rd_ff;
                  held_ff <= held_ff + HW'(1);
               end
               i_ff     <= i_ff + 8'd1;
               state_ff <= ST_SCAN_ADDR;
            end
            ST_TW_RD1: state_ff <= ST_TW_RD2;
            ST_TW_RD2: begin
               y_ff     <= {tw_rda_ff[31], tw_rdb_ff[30:0]};
               state_ff <= ST_TW_CALC;
            end
            ST_TW_CALC: begin
               pos_ff <= pos_next;
               if (raw_ff) begin
                  rsp_valid <= 1'b1;
                  rsp_value <= temper(twisted);
                  state_ff  <= ST_IDLE;
               end else begin
                  word_ff  <= temper(twisted);
                  rem_ff   <= '0;
                  bit_ff   <= 5'd31;
                  state_ff <= ST_MOD;
               end
            end
            ST_MOD: begin
               rem_ff  <= rem_in;
               word_ff <= {word_ff[30:0], 1'b0};
               bit_ff  <= bit_ff - 5'd1;
               if (bit_ff == 5'd0) state_ff <= ST_PICK;
            end
            ST_PICK: begin
               rsp_valid <= 1'b1;
               rsp_value <= {16'b0, picks_ff[rem_ff[PIW-1:0]]};
               state_ff  <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/random_walk_next_hop.sv
// Next-hop chooser for a random walk over a road graph held in on-chip stores.
// A transaction is offered with start and taken at a clock edge where busy is
// low. Actions 0 and 1 load a node entry or a link entry and return nothing.
// Action 2 steps from current_node, avoiding came_from, and action 3 returns a
// raw word from the shared MT19937 generator. Each result appears on rsp_value
// for exactly one cycle with rsp_valid high; the receiver cannot stall, so no
// result is ever held back. The register node_count is written with csr_we.
// Transactions pass a two-entry queue; busy is high while it is full.
// In the back end a write, or a step from a node out of range, retires in
// the idle state, and a draw passes through the generator read and calculate
// states. Any other step reads the node entry, then scans its links through an
// address and a data state each (a link past the link store skips the data
// state), plus the generator states and the bit-serial modulo when a candidate
// exists. The serial link scan and the modulo loop set the rate. After reset
// a seeding pass computes the generator words one at a time in the multiplier;
// busy stays high throughout it, while csr writes are still taken.
module random_walk_next_hop
   import rwnh_pkg::*;
#(
   parameter int NODE_DEPTH = 1024,
   parameter int LINK_DEPTH = 4096,
   parameter int MAX_PICKS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_entry_index,
   input  logic [11:0] req_first_link,
   input  logic [7:0]  req_link_count,
   input  logic [15:0] req_link_target,
   input  logic [15:0] req_current_node,
   input  logic [15:0] req_came_from,
   output logic        rsp_valid,
   output logic [31:0] rsp_value,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);

   logic        push;
   cmd_type     push_cmd;
   logic        queue_full;
   logic        head_valid;
   cmd_type     head_cmd;
   logic        pop;
   logic        init_busy;
   logic [10:0] node_count_ff;

   // The node count register must only be written while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 11'd0;
      end else if (csr_we) begin
         node_count_ff <= csr_wdata;
      end
   end

   // Busy covers both the seeding pass and a full queue.
   assign busy = queue_full || init_busy;

   rwnh_front #(
      .NODE_DEPTH(NODE_DEPTH),
      .LINK_DEPTH(LINK_DEPTH)
   ) u_front (
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_entry_index  (req_entry_index),
      .req_first_link   (req_first_link),
      .req_link_count   (req_link_count),
      .req_link_target  (req_link_target),
      .req_current_node (req_current_node),
      .req_came_from    (req_came_from),
      .push             (push),
      .cmd              (push_cmd)
   );

   rwnh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   rwnh_back #(
      .NODE_DEPTH(NODE_DEPTH),
      .LINK_DEPTH(LINK_DEPTH),
      .MAX_PICKS (MAX_PICKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .node_count (node_count_ff),
      .cmd_pop    (pop),
      .init_busy  (init_busy),
      .rsp_valid  (rsp_valid),
      .rsp_value  (rsp_value)
   );

endmodule

FILE: hw/rtl/rwnh_checker.sv
module rwnh_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // Reset starts the seeding pass, so the block must report busy right after.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // No result can come out of a block that was just reset.
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // Without a new transaction the queue cannot fill and seeding cannot restart.
   a_idle_stays: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !busy)
      else $error("busy rose without a transaction");

endmodule

bind random_walk_next_hop rwnh_checker u_rwnh_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the random-walk next-hop chooser. The bench keeps
// its own copy of the road graph, the node count and the MT19937 generator.
// Every accepted transaction is run through that copy. Steps and draws push
// their expected value into a queue. A monitor compares each strobed result
// with the oldest entry of that queue.
module testbench;
   import rwnh_pkg::*;

   localparam int NODES     = 1024;
   localparam int LINKS     = 4096;
   localparam int PICKS     = 8;
   localparam int MT_LEN    = 624;
   localparam int MT_SHIFT  = 397;
   localparam int SETTLE    = 700;      // more than the longest step in the back end
   localparam int MAX_CYCLE = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = ACT_DRAW;
   logic [11:0] req_entry_index = '0;
   logic [11:0] req_first_link = '0;
   logic [7:0]  req_link_count = '0;
   logic [15:0] req_link_target = '0;
   logic [15:0] req_current_node = '0;
   logic [15:0] req_came_from = '0;
   logic        rsp_valid;
   logic [31:0] rsp_value;
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   random_walk_next_hop DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_entry_index(req_entry_index),
      .req_first_link(req_first_link), .req_link_count(req_link_count),
      .req_link_target(req_link_target), .req_current_node(req_current_node),
      .req_came_from(req_came_from), .rsp_valid(rsp_valid), .rsp_value(rsp_value),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the block: graph stores with written flags, so that the
   // stimulus never steps onto an entry that was never loaded.
   logic [11:0] graph_first [NODES];
   logic [7:0]  graph_count [NODES];
   logic [15:0] graph_dest  [LINKS];
   bit          node_loaded [NODES];
   bit          link_loaded [LINKS];
   logic [10:0] node_limit_reg;
   logic [31:0] mt_state [MT_LEN];
   int unsigned mt_idx;

   logic [31:0] next_hop_queue [$];
   bit          failed = 1'b0;
   bit          idle_on = 1'b1;
   int unsigned cycle_count = 0;

   function automatic int unsigned node_limit();
      return (node_limit_reg < NODES) ? node_limit_reg : NODES;
   endfunction

   // Seeds the generator exactly as the block does after reset.
   function automatic void seed_generator();
      mt_state[0] = TW_SEED;
      for (int k = 1; k < MT_LEN; k++)
         mt_state[k] = TW_MULT * (mt_state[k-1] ^ (mt_state[k-1] >> 30)) + k;
      mt_idx = MT_LEN;
   endfunction

   // One tempered generator word; all 624 words are regenerated when used up.
   function automatic logic [31:0] next_word();
      logic [31:0] y, v;
      if (mt_idx >= MT_LEN) begin
         for (int k = 0; k < MT_LEN; k++) begin
            y = (mt_state[k] & 32'h80000000) | (mt_state[(k+1) % MT_LEN] & 32'h7fffffff);
            v = mt_state[(k + MT_SHIFT) % MT_LEN] ^ (y >> 1);
            if (y[0]) v = v ^ TW_MAGIC;
            mt_state[k] = v;
         end
         mt_idx = 0;
      end
      y = mt_state[mt_idx];
      mt_idx++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TW_TEMPER_B);
      y = y ^ ((y << 15) & TW_TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // True when a step from this node reads only loaded entries.
   function automatic bit step_is_safe(logic [15:0] node);
      if (node >= node_limit()) return 1'b1;
      if (!node_loaded[node]) return 1'b0;
      for (int i = 0; i < graph_count[node]; i++)
         if (graph_first[node] + i < LINKS && !link_loaded[graph_first[node] + i])
            return 1'b0;
      return 1'b1;
   endfunction

   // Applies one accepted transaction to the shadow copy and queues the
   // expected value for steps and draws.
   function automatic void predict_hop(logic [1:0] act, logic [11:0] idx, logic [11:0] first,
                                       logic [7:0] cnt, logic [15:0] target,
                                       logic [15:0] node, logic [15:0] from);
      logic [15:0] picks [PICKS];
      int unsigned held;
      int unsigned li;
      logic [15:0] to;
      case (act)
         ACT_NODE_WR: begin
            if (idx < NODES) begin
               graph_first[idx] = first;
               graph_count[idx] = cnt;
               node_loaded[idx] = 1'b1;
            end
         end
         ACT_LINK_WR: begin
            graph_dest[idx] = target;
            link_loaded[idx] = 1'b1;
         end
         ACT_DRAW: next_hop_queue.push_back(next_word());
         default: begin
            held = 0;
            if (node < node_limit()) begin
               for (int i = 0; i < graph_count[node] && held < PICKS; i++) begin
                  li = graph_first[node] + i;
                  if (li < LINKS) begin
                     to = graph_dest[li];
                     if (to < node_limit() && to != from) begin
                        picks[held] = to;
                        held++;
                     end
                  end
               end
            end
            if (held == 0) next_hop_queue.push_back({16'h0, from});
            else next_hop_queue.push_back({16'h0, picks[next_word() % held]});
         end
      endcase
   endfunction

   // Offers one transaction from a falling edge and holds it until the block
   // takes it at a rising edge with busy low. Random idle cycles go first while idle_on is set.
   task automatic send_item(int act, int idx, int first, int cnt, int target,
                            int node, int from);
      while (idle_on && $urandom_range(0, 99) < 30) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_action = 2'(act);
      req_entry_index = 12'(idx);
      req_first_link = 12'(first);
      req_link_count = 8'(cnt);
      req_link_target = 16'(target);
      req_current_node = 16'(node);
      req_came_from = 16'(from);
      do @(posedge clock); while (busy);
      predict_hop(req_action, req_entry_index, req_first_link, req_link_count,
                  req_link_target, req_current_node, req_came_from);
   endtask

   task automatic node_write(int idx, int first, int cnt);
      send_item(ACT_NODE_WR, idx, first, cnt, $urandom, $urandom, $urandom);
   endtask

   task automatic link_write(int idx, int target);
      send_item(ACT_LINK_WR, idx, $urandom, $urandom, target, $urandom, $urandom);
   endtask

   task automatic step_from(int node, int from);
      send_item(ACT_STEP, $urandom, $urandom, $urandom, $urandom, node, from);
   endtask

   task automatic draw_raw();
      send_item(ACT_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   // Stops offering, waits for every expected result and then for the back
   // end to retire writes that produce nothing, so the register can change.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      wait (next_hop_queue.size() == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_node_count(logic [10:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      node_limit_reg = value;
   endtask

   // Loads a small graph. Node 0 has twelve good links so the candidate
   // limit is hit, node 1 leads only to node 5, node 2 starts near the end
   // of the link store so most of its links lie past it, node 3 has none.
   task automatic test_graph_load();
      for (int i = 0; i < 64; i++)
         link_write(i, (i < 12) ? i + 1 : (i < 15) ? 5 : $urandom_range(0, 40));
      for (int i = 4090; i < LINKS; i++) link_write(i, i - 4087);
      node_write(0, 0, 12);
      node_write(1, 12, 3);
      node_write(2, 4090, 255);
      node_write(3, 0, 0);
      for (int n = 4; n < 16; n++) node_write(n, $urandom_range(0, 58), $urandom_range(1, 6));
   endtask

   // Extremes and every special case, each with a known shape.
   task automatic test_directed();
      step_from(0, 7);                 // node count still zero: out of range
      draw_raw();
      drain();
      set_node_count(11'd32);
      step_from(0, 3);                 // candidate limit
      step_from(1, 5);                 // every target equals the origin
      step_from(1, 9);
      step_from(2, 4);                 // links past the store are skipped
      step_from(3, 3);                 // no links at all
      step_from(32, 1);                // first id out of range
      step_from(16'hffff, 16'hffff);
      node_write(4095, 12'hfff, 8'hff); // write past the node store is dropped
      node_write(1024, 12'h800, 8'h80);
      link_write(4095, 16'hffff);
      link_write(4095, 4);
      for (int i = 0; i < 4; i++) draw_raw();
      drain();
      set_node_count(11'd2047);         // above the store: clamps to its depth
      step_from(0, 0);
      step_from(2, 16'h8000);
      step_from(1024, 16'h1234);        // first id past the clamped count
      drain();
      set_node_count(11'd4);            // targets above 3 drop out
      step_from(0, 1);
      step_from(2, 3);
      drain();
   endtask

   // Mostly steps on the loaded graph and draws, with writes that keep the
   // graph walkable and some node writes that fall outside the node store.
   task automatic test_random(int items, logic [10:0] count_value, bit idle);
      int pick, node, from;
      set_node_count(count_value);
      idle_on = idle;
      for (int k = 0; k < items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            if ($urandom_range(0, 3) == 0)
               node_write($urandom_range(NODES, 4095), $urandom, $urandom);
            else begin
               node = $urandom_range(0, 58);
               node_write($urandom_range(0, 31), node, $urandom_range(0, 64 - node));
            end
         end else if (pick < 20) begin
            link_write($urandom_range(0, 4095),
                       ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40));
         end else if (pick < 80) begin
            do begin
               node = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 31);
            end while (!step_is_safe(16'(node)));
            from = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
            step_from(node, from);
         end else begin
            draw_raw();
         end
      end
      drain();
      idle_on = 1'b1;
   endtask

   // Result checker: the receiver never stalls, so each strobe is a result.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (next_hop_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_value);
            failed = 1'b1;
         end else begin
            if (rsp_value !== next_hop_queue[0]) begin
               $display("%0t: value mismatch, expected %h, actual %h",
                        $time, next_hop_queue[0], rsp_value);
               failed = 1'b1;
            end
            void'(next_hop_queue.pop_front());
         end
      end
   end

   // Watchdog for a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
         $display("[random_walk_next_hop] ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NODES; i++) node_loaded[i] = 1'b0;
      for (int i = 0; i < LINKS; i++) link_loaded[i] = 1'b0;
      node_limit_reg = '0;
      seed_generator();
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_graph_load();
      test_directed();
      test_random(90, 11'd32, 1'b1);
      test_random(80, 11'd1024, 1'b0);   // back to back, no idle cycles
      test_random(60, 11'd20, 1'b1);
      test_random(60, 11'd2047, 1'b1);
      test_random(25, 11'd1, 1'b1);
      test_random(25, 11'd1365, 1'b1);
      if (!failed) begin
         $display("[random_walk_next_hop] OK");
      end else begin
         $display("[random_walk_next_hop] ERROR");
      end
      $finish;
   end
endmodule
